@@ hdl/lpc_pkg.sv @@
// Package with shared types, constants and tables of the linked peak compressor.
`timescale 1ns / 1ps
package lpc_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEFF_BITS_DEF  = 24;
    localparam int CFG_WIDTH       = 24;
    localparam int CFG_IDX_BITS    = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOPE     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MONO      = 3'd4;

    localparam logic [15:0] FLOOR_DB     = 16'd30720;
    localparam logic [18:0] LOG2_TO_DB_K = 19'd394566;
    localparam logic [13:0] DB_TO_LOG2_K = 14'd10885;
    localparam logic [24:0] GAIN_ONE     = 25'd16777216;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV,
        ST_NORM,
        ST_LOG,
        ST_ATT,
        ST_GR,
        ST_EXP,
        ST_INTERP,
        ST_SHIFT,
        ST_SMOOTH,
        ST_OUT_L,
        ST_OUT_R,
        ST_DONE
    } lpc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic env;
        logic norm;
        logic log_step;
        logic att;
        logic gr;
        logic exp;
        logic interp;
        logic shift;
        logic smooth;
        logic out_l;
        logic out_r;
        logic publish;
    } lpc_cmd_t;

    function automatic logic [24:0] pow2_neg(input logic [4:0] i);
        logic [24:0] v;
        case (i)
            5'd0:  v = 25'd16777216;
            5'd1:  v = 25'd16065917;
            5'd2:  v = 25'd15384775;
            5'd3:  v = 25'd14732511;
            5'd4:  v = 25'd14107901;
            5'd5:  v = 25'd13509772;
            5'd6:  v = 25'd12937002;
            5'd7:  v = 25'd12388516;
            5'd8:  v = 25'd11863283;
            5'd9:  v = 25'd11360319;
            5'd10: v = 25'd10878679;
            5'd11: v = 25'd10417458;
            5'd12: v = 25'd9975792;
            5'd13: v = 25'd9552851;
            5'd14: v = 25'd9147842;
            5'd15: v = 25'd8760003;
            5'd16: v = 25'd8388608;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/lpc_ctrl.sv @@
// Controller state machine that sequences one frame through the datapath.
`timescale 1ns / 1ps
module lpc_ctrl
    import lpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic     out_free,
    input  logic     log_skip,
    output lpc_cmd_t cmd
);

    lpc_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ENV;
                end
            end
            ST_ENV:
            begin
                cmd.env    = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                cmd.norm   = 1'b1;
                cnt_next   = '0;
                state_next = log_skip ? ST_ATT : ST_LOG;
            end
            ST_LOG:
            begin
                cmd.log_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = ST_ATT;
            end
            ST_ATT:
            begin
                cmd.att    = 1'b1;
                state_next = ST_GR;
            end
            ST_GR:
            begin
                cmd.gr     = 1'b1;
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                cmd.exp    = 1'b1;
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = ST_SMOOTH;
            end
            ST_SMOOTH:
            begin
                cmd.smooth = 1'b1;
                state_next = ST_OUT_L;
            end
            ST_OUT_L:
            begin
                cmd.out_l  = 1'b1;
                state_next = ST_OUT_R;
            end
            ST_OUT_R:
            begin
                cmd.out_r  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/lpc_datapath.sv @@
// Datapath: envelope, log, gain computer, gain smoothing and output stage.
`timescale 1ns / 1ps
module lpc_datapath
    import lpc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = COEFF_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpc_cmd_t                      cmd,
    output logic                          log_skip,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  logic                          last_in_block,
    input  logic                          cfg_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_WIDTH-1:0]          cfg_data,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic [14:0]                   reduction_db,
    output logic [15:0]                   block_meter
);

    localparam int MB = SAMPLE_BITS;          // magnitude bits
    localparam int PB = $clog2(MB);           // msb position bits
    localparam int XB = 32;                   // Q2.30
    localparam int CB = COEFF_BITS;
    localparam int EB = CB + MB + 1;          // one-pole product width
    localparam int GB = CB + 26;              // gain one-pole width
    localparam int OB = SAMPLE_BITS + 26;     // output product width
    localparam logic [CB:0] ONE_C = {1'b1, {CB{1'b0}}};
    localparam logic [OB-1:0] OUT_HI = OB'((64'd1 << (SAMPLE_BITS - 1)) - 1);

    // configuration
    logic [CB-1:0]       attack_reg, release_reg;
    logic signed [15:0]  thresh_reg;
    logic [15:0]         slope_reg;
    logic                mono_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= CB'(64'd16774720);
            release_reg <= CB'(64'd16776852);
            thresh_reg  <= -16'sd1280;
            slope_reg   <= 16'd10923;
            mono_reg    <= 1'b0;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                REG_ATTACK:    attack_reg  <= CB'(cfg_data);
                REG_RELEASE:   release_reg <= CB'(cfg_data);
                REG_THRESHOLD: thresh_reg  <= cfg_data[15:0];
                REG_SLOPE:     slope_reg   <= cfg_data[15:0];
                REG_MONO:      mono_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // frame and state registers
    logic signed [SAMPLE_BITS-1:0] l_reg, r_reg;
    logic                          last_reg;
    logic [MB-1:0]                 det_reg;
    logic [MB-1:0]                 env_reg;
    logic [24:0]                   gain_reg;
    logic [15:0]                   peak_reg;
    logic [PB-1:0]                 pos_reg;
    logic [XB-1:0]                 x_reg;
    logic [15:0]                   frac_reg;
    logic [15:0]                   att_reg;
    logic [15:0]                   gr_reg;
    logic [4:0]                    n_reg;
    logic [3:0]                    idx_reg;
    logic [11:0]                   rem_reg;
    logic [24:0]                   v_reg;
    logic [24:0]                   target_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg, ro_reg;
    logic signed [SAMPLE_BITS-1:0] lo_out_reg, ro_out_reg;
    logic [14:0]                   red_out_reg;
    logic [15:0]                   meter_out_reg;

    // detector
    logic [MB-1:0] al, ar;
    assign al = left_sample[SAMPLE_BITS-1] ? MB'(-left_sample) : MB'(left_sample);
    assign ar = right_sample[SAMPLE_BITS-1] ? MB'(-right_sample) : MB'(right_sample);

    // envelope one pole
    logic [CB-1:0] env_c;
    logic [EB-1:0] env_sum;
    assign env_c   = (det_reg > env_reg) ? attack_reg : release_reg;
    assign env_sum = EB'(env_c) * EB'(env_reg) + EB'(ONE_C - {1'b0, env_c}) * EB'(det_reg)
                   + EB'(ONE_C >> 1);

    // leading one search (narrow priority encoder)
    logic [PB-1:0] msb_pos;
    always_comb
    begin
        msb_pos = '0;
        for (int k = 0; k < MB; k++)
            if (env_reg[k])
                msb_pos = PB'(k);
    end

    assign log_skip = (env_reg == '0) || env_reg[MB-1];

    // one squaring step of the log unit
    logic [2*XB-1:0] sq;
    logic [XB-1:0]   sq30;
    assign sq   = {{XB{1'b0}}, x_reg} * {{XB{1'b0}}, x_reg};
    assign sq30 = XB'(sq >> 30);

    // attenuation
    logic [23:0] a_val;
    logic [43:0] att_prod;
    logic [43:0] att_full;
    assign a_val    = 24'(MB - 1 - int'(pos_reg)) * 24'd65536 - 24'(frac_reg);
    assign att_prod = 44'(a_val) * 44'(LOG2_TO_DB_K) + 44'd8388608;
    assign att_full = att_prod >> 24;

    // reduction
    logic signed [17:0] over;
    logic [33:0]        gr_prod;
    logic [17:0]        gr_raw;
    assign over    = -18'(thresh_reg) - 18'(att_reg);
    assign gr_prod = (over < 0 ? 34'd0 : 34'(over)) * 34'(slope_reg) + 34'd32768;
    assign gr_raw  = 18'(gr_prod >> 16);

    // exponent
    logic [29:0] e_val;
    assign e_val = (30'(gr_reg) * 30'(DB_TO_LOG2_K) + 30'd128) >> 8;

    // interpolation
    logic [24:0] t0, t1;
    logic [36:0] ip;
    assign t0 = pow2_neg({1'b0, idx_reg});
    assign t1 = pow2_neg(5'({1'b0, idx_reg}) + 5'd1);
    assign ip = (37'(t0 - t1) * 37'(rem_reg) + 37'd2048) >> 12;

    // integer shift
    logic [25:0] sh_val;
    assign sh_val = (n_reg == 5'd0) ? 26'(v_reg)
                  : (n_reg > 5'd24) ? 26'd0
                  : ((26'(v_reg) + (26'd1 << (n_reg - 5'd1))) >> n_reg);

    // gain one pole
    logic [CB-1:0] g_c;
    logic [GB-1:0] g_sum;
    assign g_c   = (target_reg < gain_reg) ? attack_reg : release_reg;
    assign g_sum = GB'(g_c) * GB'(gain_reg) + GB'(ONE_C - {1'b0, g_c}) * GB'(target_reg)
                 + GB'(ONE_C >> 1);

    // output multiply, one channel per cycle
    logic signed [SAMPLE_BITS-1:0] osrc;
    logic signed [OB-1:0]          oprod, oshift;
    logic signed [SAMPLE_BITS-1:0] osat;
    assign osrc   = cmd.out_l ? l_reg : r_reg;
    assign oprod  = OB'(osrc) * $signed({1'b0, gain_reg}) + OB'(64'd8388608);
    assign oshift = oprod >>> 24;
    assign osat   = (oshift > $signed(OUT_HI)) ? SAMPLE_BITS'(OUT_HI)
                  : (oshift < -$signed(OUT_HI) - 1) ? SAMPLE_BITS'(-OUT_HI - 1)
                  : SAMPLE_BITS'(oshift);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg  <= '0;
            gain_reg <= GAIN_ONE;
            peak_reg <= '0;
        end
        else
        begin
            if (cmd.env)
                env_reg <= MB'(env_sum >> CB);
            if (cmd.smooth)
                gain_reg <= 25'(g_sum >> CB);
            if (cmd.gr && (16'(gr_raw > 18'(FLOOR_DB) ? 18'(FLOOR_DB) : gr_raw) > peak_reg))
                peak_reg <= 16'(gr_raw > 18'(FLOOR_DB) ? 18'(FLOOR_DB) : gr_raw);
            // The block peak is cleared only once the meter word has captured it.
            if (cmd.publish && last_reg)
                peak_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            l_reg    <= left_sample;
            r_reg    <= right_sample;
            last_reg <= last_in_block;
            det_reg  <= (mono_reg || al >= ar) ? al : ar;
        end
        if (cmd.norm)
        begin
            pos_reg  <= msb_pos;
            x_reg    <= XB'({{(XB-MB){1'b0}}, env_reg} << (30 - int'(msb_pos)));
            frac_reg <= '0;
        end
        if (cmd.log_step)
        begin
            frac_reg <= {frac_reg[14:0], sq30[31]};
            x_reg    <= sq30[31] ? (sq30 >> 1) : sq30;
        end
        if (cmd.att)
        begin
            if (env_reg == '0)
                att_reg <= FLOOR_DB;
            else if (env_reg[MB-1])
                att_reg <= '0;
            else
                att_reg <= (att_full > 44'(FLOOR_DB)) ? FLOOR_DB : 16'(att_full);
        end
        if (cmd.gr)
            gr_reg <= 16'(gr_raw > 18'(FLOOR_DB) ? 18'(FLOOR_DB) : gr_raw);
        if (cmd.exp)
        begin
            n_reg   <= (e_val[29:16] > 14'd25) ? 5'd25 : 5'(e_val[29:16]);
            idx_reg <= e_val[15:12];
            rem_reg <= e_val[11:0];
        end
        if (cmd.interp)
            v_reg <= t0 - 25'(ip);
        if (cmd.shift)
            target_reg <= 25'(sh_val);
        if (cmd.out_l)
            lo_reg <= osat;
        if (cmd.out_r)
            ro_reg <= mono_reg ? '0 : osat;
        if (cmd.publish)
        begin
            lo_out_reg    <= lo_reg;
            ro_out_reg    <= ro_reg;
            red_out_reg   <= gr_reg[14:0];
            meter_out_reg <= last_reg ? ((gr_reg > peak_reg ? gr_reg : peak_reg) > 16'd2047
                             ? 16'hFFFF : 16'((gr_reg > peak_reg ? gr_reg : peak_reg) << 5))
                             : 16'd0;
        end
    end

    assign left_out     = lo_out_reg;
    assign right_out    = ro_out_reg;
    assign reduction_db = red_out_reg;
    assign block_meter  = meter_out_reg;

endmodule

@@ hdl/linked_peak_compressor_top.sv @@
// Top level of the stereo-linked feed-forward peak compressor.
`timescale 1ns / 1ps
// The controller steps each accepted frame through the datapath to its result register;
// the level-to-dB conversion squares once per fraction bit, skipped when the envelope
// is zero or at full scale. Frames are processed one at a time; a finished word waits
// in the output register while the next frame is taken, so a downstream stall only
// blocks once a second word is ready.
module linked_peak_compressor_top
    import lpc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = COEFF_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  logic                          last_in_block,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic [14:0]                   reduction_db,
    output logic [15:0]                   block_meter,
    input  logic                          cfg_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_WIDTH-1:0]          cfg_data
);

    lpc_cmd_t cmd;
    logic     log_skip;
    logic     out_valid_reg;
    logic     out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;

    lpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_free (out_free),
        .log_skip (log_skip),
        .cmd      (cmd)
    );

    lpc_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .log_skip      (log_skip),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .last_in_block (last_in_block),
        .cfg_en        (cfg_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .left_out      (left_out),
        .right_out     (right_out),
        .reduction_db  (reduction_db),
        .block_meter   (block_meter)
    );

endmodule

@@ test/linked_peak_compressor_top_test.sv @@
// Self-checking testbench of the stereo-linked peak compressor with a bit-exact predictor.
`timescale 1ns / 1ps
module linked_peak_compressor_top_test;
    import lpc_pkg::*;

    localparam int SB = 24;
    localparam int CB = 24;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;

    typedef struct {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic                 last;
    } frame_t;

    typedef struct {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic [14:0]          red;
        logic [15:0]          meter;
    } gain_word_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [SB-1:0] left_sample;
    logic signed [SB-1:0] right_sample;
    logic last_in_block;
    logic out_valid;
    logic out_stall;
    logic signed [SB-1:0] left_out;
    logic signed [SB-1:0] right_out;
    logic [14:0] reduction_db;
    logic [15:0] block_meter;
    logic cfg_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;

    linked_peak_compressor_top dut (.*);

    // Predictor state and register copies.
    logic [63:0] p_attack, p_release, p_slope, p_mono;
    int          p_thresh;
    logic [63:0] p_env, p_gain, p_peak;

    frame_t     frames_pending[$];
    gain_word_t compressed_words[$];
    int  errors;
    bit  feed_enable;
    int  hold_cycles;
    int  burst_left;
    int  gap_left;

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [63:0] one_pole(logic [63:0] y, logic [63:0] x, logic [63:0] c);
        logic [63:0] one;
        one = 64'd1 << CB;
        return (c * y + (one - c) * x + (one >> 1)) >> CB;
    endfunction

    function automatic logic [63:0] atten_db(logic [63:0] env);
        logic [63:0] x, frac, a, att;
        int p;
        frac = 0;
        p = 0;
        if (env == 0) return 64'(FLOOR_DB);
        if (env >= (64'd1 << (SB - 1))) return 0;
        for (int k = 0; k < 63; k++)
            if (env[k]) p = k;
        x = env << (30 - p);
        for (int k = 0; k < 16; k++)
        begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd2 << 30))
            begin
                frac = frac | 1;
                x = x >> 1;
            end
        end
        a = 64'(SB - 1 - p) * 65536 - frac;
        att = (a * 64'd394566 + (64'd1 << 23)) >> 24;
        return att > 30720 ? 64'd30720 : att;
    endfunction

    function automatic logic [63:0] gain_of_db(logic [63:0] gr);
        logic [63:0] tab [17];
        logic [63:0] e, n, f, idx, rem, v;
        tab = '{16777216, 16065917, 15384775, 14732511, 14107901, 13509772,
                12937002, 12388516, 11863283, 11360319, 10878679, 10417458,
                9975792, 9552851, 9147842, 8760003, 8388608};
        e = (gr * 10885 + 128) >> 8;
        n = e >> 16;
        f = e & 64'hFFFF;
        idx = f >> 12;
        rem = f & 64'hFFF;
        v = tab[idx] - (((tab[idx] - tab[idx + 1]) * rem + 2048) >> 12);
        if (n == 0) return v;
        if (n > 24) return 0;
        return (v + (64'd1 << (n - 1))) >> n;
    endfunction

    function automatic logic signed [SB-1:0] scale_sample(longint s, logic [63:0] g);
        longint prod, r, hi;
        prod = s * longint'(g);
        r = prod >>> 24;
        if (prod[23]) r = r + 1;
        hi = (longint'(1) << (SB - 1)) - 1;
        if (r > hi) r = hi;
        if (r < -hi - 1) r = -hi - 1;
        return r[SB-1:0];
    endfunction

    task automatic predict_frame(input frame_t fr);
        longint l, r;
        logic [63:0] al, ar, det, gr, target, meter;
        int over;
        gain_word_t w;
        l = fr.left;
        r = fr.right;
        al = l < 0 ? -l : l;
        ar = r < 0 ? -r : r;
        det = (p_mono != 0 || al >= ar) ? al : ar;
        p_env = one_pole(p_env, det, det > p_env ? p_attack : p_release);
        over = -p_thresh - int'(atten_db(p_env));
        if (over < 0) over = 0;
        gr = (64'(over) * p_slope + 32768) >> 16;
        if (gr > 30720) gr = 30720;
        target = gain_of_db(gr);
        p_gain = one_pole(p_gain, target, target < p_gain ? p_attack : p_release);
        if (gr > p_peak) p_peak = gr;
        meter = 0;
        if (fr.last)
        begin
            meter = p_peak * 32;
            if (meter > 65535) meter = 65535;
            p_peak = 0;
        end
        w.left = scale_sample(l, p_gain);
        w.right = p_mono != 0 ? '0 : scale_sample(r, p_gain);
        w.red = gr[14:0];
        w.meter = meter[15:0];
        compressed_words.insert(compressed_words.size(), w);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [23:0] val);
        @(posedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_en <= 1'b0;
        case (idx)
            REG_ATTACK:    p_attack = 64'(val);
            REG_RELEASE:   p_release = 64'(val);
            REG_THRESHOLD: p_thresh = int'($signed(val[15:0]));
            REG_SLOPE:     p_slope = 64'(val[15:0]);
            REG_MONO:      p_mono = 64'(val[0]);
            default:       ;
        endcase
    endtask

    task automatic queue_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                               input logic last);
        frame_t fr;
        fr.left = l;
        fr.right = r;
        fr.last = last;
        frames_pending.insert(frames_pending.size(), fr);
    endtask

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return SB'($urandom_range(0, 255));
            3: return -$signed({1'b0, 23'($urandom_range(0, 4095))});
            default: return SB'($urandom);
        endcase
    endfunction

    task automatic drain();
        while (frames_pending.size() != 0 || compressed_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            queue_frame(rand_sample(), rand_sample(), $urandom_range(0, 15) == 0);
        queue_frame(rand_sample(), rand_sample(), 1'b1);
        drain();
    endtask

    // Sender: bursts and gaps; a word stays put while it is stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_frame(frames_pending.pop_front());
            end
            if (in_valid && in_stall)
            begin
                // hold current word
            end
            else if (feed_enable && frames_pending.size() != 0 && gap_left == 0)
            begin
                in_valid <= 1'b1;
                left_sample <= frames_pending[0].left;
                right_sample <= frames_pending[0].right;
                last_in_block <= frames_pending[0].last;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
            begin
                in_valid <= 1'b0;
                if (gap_left != 0) gap_left <= gap_left - 1;
            end
        end
    end

    // Receiver: random stall pattern plus an occasional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (compressed_words.size() == 0)
                begin
                    report_mismatch("unexpected word", 32'(left_out), 32'd0);
                end
                else
                begin
                    gain_word_t w;
                    w = compressed_words.pop_front();
                    if (left_out !== w.left) report_mismatch("left_out", left_out, w.left);
                    if (right_out !== w.right) report_mismatch("right_out", right_out, w.right);
                    if (reduction_db !== w.red)
                        report_mismatch("reduction_db", reduction_db, w.red);
                    if (block_meter !== w.meter)
                        report_mismatch("block_meter", block_meter, w.meter);
                end
            end
            if (hold_cycles != 0)
            begin
                out_stall <= 1'b1;
                hold_cycles <= hold_cycles - 1;
            end
            else if ($urandom_range(0, 400) == 0)
            begin
                hold_cycles <= 300;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < 30) && (($time % 20000) < 14000);
        end
    end

    initial
    begin
        errors = 0;
        feed_enable = 0;
        hold_cycles = 0;
        rst_n = 0;
        in_valid = 0;
        left_sample = 0;
        right_sample = 0;
        last_in_block = 0;
        cfg_en = 0;
        cfg_index = 0;
        cfg_data = 0;
        p_attack = 16774720;
        p_release = 16776852;
        p_thresh = -1280;
        p_slope = 10923;
        p_mono = 0;
        p_env = 0;
        p_gain = 64'd1 << 24;
        p_peak = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: fast poles so reduction appears quickly, then extremes.
        write_reg(REG_ATTACK, 24'd0);
        write_reg(REG_RELEASE, 24'd0);
        write_reg(REG_THRESHOLD, 24'(-16'sd3840));
        write_reg(REG_SLOPE, 24'd65535);
        write_reg(REG_MONO, 24'd0);
        write_reg(REG_UNMAPPED, 24'h123456);
        feed_enable = 1;
        queue_frame(24'sd0, 24'sd0, 1'b0);
        queue_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
        queue_frame(24'sh800000, 24'sh7FFFFF, 1'b1);
        queue_frame(24'sd1, -24'sd1, 1'b0);
        queue_frame(24'sh000100, 24'sh400000, 1'b0);
        queue_frame(-24'sh200000, 24'sh000010, 1'b1);
        queue_frame(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        drain();
        write_reg(REG_THRESHOLD, 24'(-16'sd30720));
        write_reg(REG_MONO, 24'd1);
        queue_frame(24'sh7FFFFF, 24'sh123456, 1'b0);
        queue_frame(24'sh800000, -24'sh1, 1'b1);
        queue_frame(24'sd0, 24'sh7FFFFF, 1'b0);
        queue_frame(24'sh000001, 24'sh800000, 1'b1);
        drain();
        write_reg(REG_THRESHOLD, 24'd0);
        write_reg(REG_SLOPE, 24'd0);
        write_reg(REG_MONO, 24'd0);
        queue_frame(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        queue_frame(24'sh000003, 24'sh800000, 1'b1);
        drain();
        write_reg(REG_THRESHOLD, 24'h007FFF);
        write_reg(REG_SLOPE, 24'd65535);
        queue_frame(24'sh7FFFFF, 24'sh800000, 1'b1);
        drain();

        // Random phases across settings, defaults and extremes included.
        write_reg(REG_ATTACK, 24'd16774720);
        write_reg(REG_RELEASE, 24'd16776852);
        write_reg(REG_THRESHOLD, 24'(-16'sd1280));
        write_reg(REG_SLOPE, 24'd10923);
        random_phase(80);
        write_reg(REG_ATTACK, 24'hFFFFFF);
        write_reg(REG_RELEASE, 24'hFFFFFF);
        write_reg(REG_SLOPE, 24'd65535);
        random_phase(60);
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_ATTACK, 24'($urandom_range(0, 24'hFFFFFF)));
            write_reg(REG_RELEASE, $urandom_range(0, 3) == 0 ? 24'd0 : 24'($urandom));
            write_reg(REG_THRESHOLD, 24'(-16'($urandom_range(0, 30720))));
            write_reg(REG_SLOPE, 24'($urandom_range(0, 65535)));
            write_reg(REG_MONO, 24'($urandom_range(0, 1)));
            random_phase(55);
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/lpc_pkg.sv
hdl/lpc_ctrl.sv
hdl/lpc_datapath.sv
hdl/linked_peak_compressor_top.sv
test/linked_peak_compressor_top_test.sv
